/* rtl/first_fit_free_list_allocator_unit_macros.svh */
// Assertion macros used by the allocator top level.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ffa_pkg.sv */
// Package: constants, types and helpers of the first-fit allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

  localparam int WORD_BYTES   = 4;
  localparam int HEADER_BYTES = 8;
  localparam int HEAP_BYTES   = 16384;
  localparam int STORE_DEPTH  = HEAP_BYTES / WORD_BYTES;
  localparam int SLOT_W       = $clog2(STORE_DEPTH);

  localparam int PTR_W   = 15;
  localparam int START_W = 14;
  localparam int LINK_W  = 16;
  localparam int END_W   = LINK_W + 1;

  localparam logic [LINK_W-1:0] NULL_LINK = {LINK_W{1'b1}};

  typedef enum logic [1:0] {
    ST_REUSED = 2'd0,
    ST_CARVED = 2'd1,
    ST_OOM    = 2'd2,
    ST_FREED  = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  typedef enum logic {
    REG_HEAP_START = 1'b0,
    REG_HEAP_LIMIT = 1'b1
  } reg_index_t;

  // Access bundle towards the header store.
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              size_we;
    logic [SLOT_W-1:0] size_slot;
    logic [PTR_W-1:0]  size_data;
    logic              next_we;
    logic [SLOT_W-1:0] next_slot;
    logic [LINK_W-1:0] next_data;
  } store_req_t;

  typedef struct packed {
    logic [PTR_W-1:0]  size;
    logic [LINK_W-1:0] link;
  } store_rsp_t;

  // Header offset to store slot: word index, wrapped to the store depth.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [LINK_W-1:0] hdr);
    logic [LINK_W-1:0] word;
    word = hdr / LINK_W'(WORD_BYTES);
    return word[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/ffa_store.sv */
// Header store: block size and free-list link per header slot.
`timescale 1ns / 1ps
`default_nettype none
module ffa_store (
  input  wire                 clk,
  input  ffa_pkg::store_req_t req,
  output ffa_pkg::store_rsp_t rsp
);
  import ffa_pkg::*;

  logic [PTR_W-1:0]  size_mem [STORE_DEPTH];
  logic [LINK_W-1:0] next_mem [STORE_DEPTH];
  logic [PTR_W-1:0]  size_q;
  logic [LINK_W-1:0] link_q;

  always_ff @(posedge clk) begin
    if (req.size_we) begin
      size_mem[req.size_slot] <= req.size_data;
    end
    if (req.rd_en) begin
      size_q <= size_mem[req.rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (req.next_we) begin
      next_mem[req.next_slot] <= req.next_data;
    end
    if (req.rd_en) begin
      link_q <= next_mem[req.rd_slot];
    end
  end

  assign rsp.size = size_q;
  assign rsp.link = link_q;

endmodule
`default_nettype wire

/* rtl/first_fit_free_list_allocator_unit.sv */
// Top level: first-fit free-list heap allocator with bump-pointer carving.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start is high and busy is low. Its result shows on
// result_ptr and status for exactly one cycle with done high; the receiver
// cannot stall it, so it must take every result as it comes. A free does not
// raise busy: its result follows on the next cycle and another request may be
// taken in that same cycle. An allocate takes the first free-list entry that
// fits, one entry per header store read; when none fits, a new block is carved
// (or out of memory is reported), with the walk capped at 4096 entries. Store
// reads are registered. Registers are written through wr_en, wr_index and
// wr_data; the user must write them only while the block is idle, which the
// block does not enforce. Writing heap_start sets the bump pointer to
// wr_data[13:0]. The store needs no clearing pass.
module first_fit_free_list_allocator_unit (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire                         req_type,
  input  wire  [ffa_pkg::PTR_W-1:0]   req_size,
  input  wire  [ffa_pkg::PTR_W-1:0]   block_ptr,
  output logic                        done,
  output logic [ffa_pkg::PTR_W-1:0]   result_ptr,
  output ffa_pkg::status_t            status,
  input  wire                         wr_en,
  input  wire                         wr_index,
  input  wire  [ffa_pkg::PTR_W-1:0]   wr_data
);
  import ffa_pkg::*;
  `include "first_fit_free_list_allocator_unit_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_CARVE = 3'b100
  } state_t;

  state_t            state;
  logic [LINK_W-1:0] free_head;
  logic [PTR_W-1:0]  bump_ptr;
  logic [PTR_W-1:0]  heap_limit;
  logic [LINK_W-1:0] need;
  logic [LINK_W-1:0] cur;
  logic [LINK_W-1:0] prev;
  logic [SLOT_W-1:0] steps;

  store_req_t        st_req;
  store_rsp_t        st_rsp;

  logic              accept;
  logic              is_free;
  logic              free_valid;
  logic [PTR_W-1:0]  free_hdr;
  logic [LINK_W-1:0] need_next;
  logic              fits;
  logic              walk_end;
  logic [END_W-1:0]  end_off;
  logic              oom;

  ffa_store u_store (
    .clk (clk),
    .req (st_req),
    .rsp (st_rsp)
  );

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign is_free    = (req_type_t'(req_type) == REQ_FREE);
  assign free_valid = (block_ptr >= PTR_W'(HEADER_BYTES));
  assign free_hdr   = block_ptr - PTR_W'(HEADER_BYTES);
  assign need_next  = (LINK_W'(req_size) + LINK_W'(WORD_BYTES - 1))
                    & ~LINK_W'(WORD_BYTES - 1);
  assign fits       = (LINK_W'(st_rsp.size) >= need);
  assign walk_end   = (st_rsp.link == NULL_LINK) || (steps == SLOT_W'(STORE_DEPTH - 1));
  assign end_off    = END_W'(bump_ptr) + END_W'(HEADER_BYTES) + END_W'(need);
  assign oom        = (end_off > END_W'(heap_limit));

  // Store accesses: one list entry read per cycle while walking.
  always_comb begin
    st_req = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && !is_free) begin
          st_req.rd_en   = 1'b1;
          st_req.rd_slot = slot_of(free_head);
        end
        if (accept && is_free && free_valid) begin
          st_req.next_we   = 1'b1;
          st_req.next_slot = slot_of(LINK_W'(free_hdr));
          st_req.next_data = free_head;
        end
      end
      S_CHECK: begin
        if (fits) begin
          st_req.next_we   = (prev != NULL_LINK);
          st_req.next_slot = slot_of(prev);
          st_req.next_data = st_rsp.link;
        end else if (!walk_end) begin
          st_req.rd_en   = 1'b1;
          st_req.rd_slot = slot_of(st_rsp.link);
        end
      end
      S_CARVE: begin
        st_req.size_we   = !oom;
        st_req.size_slot = slot_of(LINK_W'(bump_ptr));
        st_req.size_data = need[PTR_W-1:0];
      end
      default: begin
        st_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= NULL_LINK;
      bump_ptr   <= '0;
      heap_limit <= PTR_W'(HEAP_BYTES);
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        unique case (reg_index_t'(wr_index))
          REG_HEAP_START: bump_ptr   <= {1'b0, wr_data[START_W-1:0]};
          REG_HEAP_LIMIT: heap_limit <= wr_data;
          default:        heap_limit <= heap_limit;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && is_free) begin
            done       <= 1'b1;
            result_ptr <= '0;
            status     <= ST_FREED;
            if (free_valid) begin
              free_head <= LINK_W'(free_hdr);
            end
          end else if (accept) begin
            need  <= need_next;
            cur   <= free_head;
            prev  <= NULL_LINK;
            steps <= '0;
            state <= (free_head == NULL_LINK) ? S_CARVE : S_CHECK;
          end
        end
        S_CHECK: begin
          if (fits) begin
            // unlink the fitting block whole
            done       <= 1'b1;
            result_ptr <= PTR_W'(cur + LINK_W'(HEADER_BYTES));
            status     <= ST_REUSED;
            if (prev == NULL_LINK) begin
              free_head <= st_rsp.link;
            end
            state <= S_IDLE;
          end else begin
            prev  <= cur;
            cur   <= st_rsp.link;
            steps <= steps + 1'b1;
            if (walk_end) begin
              state <= S_CARVE;
            end
          end
        end
        S_CARVE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (oom) begin
            result_ptr <= '0;
            status     <= ST_OOM;
          end else begin
            result_ptr <= bump_ptr + PTR_W'(HEADER_BYTES);
            status     <= ST_CARVED;
            bump_ptr   <= end_off[PTR_W-1:0];
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FFA_ASSERT_NOW(a_done_when_idle, clk, rst, done, !busy, "result strobe while busy")
  `FFA_ASSERT_NEXT(a_free_one_cycle, clk, rst, accept && is_free,
                   done && status == ST_FREED && result_ptr == '0, "free result missing")
  `FFA_ASSERT_NOW(a_oom_null, clk, rst, done && status == ST_OOM, result_ptr == '0,
                  "out of memory with non-null pointer")

endmodule
`default_nettype wire
